/* hdl/v4sub_pkg.sv */
// shared constants for the ipv4 text subnet calculator
// character codes, octet limits and status codes; no dependencies

package v4sub_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AccumW  = 10;
  localparam int unsigned DigitW  = 2;
  localparam int unsigned PosW    = 3;

  localparam logic [CharW-1:0] CharDot  = 8'h2E;
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;

  localparam logic [AccumW-1:0] OctetMax   = 10'd255;
  localparam logic [PosW-1:0]   OctetCount = 3'd4;
  localparam logic [PosW-1:0]   LastOctet  = 3'd3;
  localparam logic [DigitW-1:0] MaxDigits  = 2'd3;

  // status codes, first error wins
  localparam logic [StatusW-1:0] StOk          = 3'd0;
  localparam logic [StatusW-1:0] StBadChar     = 3'd1;
  localparam logic [StatusW-1:0] StTooManyDig  = 3'd2;
  localparam logic [StatusW-1:0] StOctetRange  = 3'd3;
  localparam logic [StatusW-1:0] StOctetCount  = 3'd4;
  localparam logic [StatusW-1:0] StMaskShape   = 3'd5;

endpackage

/* hdl/ipv4_text_subnet_calculator.sv */
// ipv4 text subnet calculator: parses address and mask texts, one character a beat
// depends on v4sub_pkg

// channel | direction | handshake          | payload
// in      | to block  | in_valid/in_stall  | char_code, end_mark
// out     | from block| out_valid/out_stall| network_addr, broadcast_addr, first_host,
//         |           |                    | last_host, status
//
// one character beat is taken every cycle unless in_stall holds it; parse state updates in the accepting cycle
// a result appears in the output register in the cycle after the mask's end mark is accepted
// the input stalls only for a mask end mark while a held result is itself stalled
// rst is synchronous: parse state and out_valid clear, result payload is not reset

module ipv4_text_subnet_calculator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [v4sub_pkg::CharW-1:0]    char_code,
  input  logic                           end_mark,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [v4sub_pkg::AddrW-1:0]    network_addr,
  output logic [v4sub_pkg::AddrW-1:0]    broadcast_addr,
  output logic [v4sub_pkg::AddrW-1:0]    first_host,
  output logic [v4sub_pkg::AddrW-1:0]    last_host,
  output logic [v4sub_pkg::StatusW-1:0]  status
);
  import v4sub_pkg::*;

  // parse state
  logic               second_text, second_text_next;
  logic [PosW-1:0]    octet_position, octet_position_next;
  logic [DigitW-1:0]  digits_seen, digits_seen_next;
  logic [AccumW-1:0]  octet_accum, octet_accum_next;
  logic [AddrW-1:0]   assembled_addr, assembled_addr_next;
  logic [AddrW-1:0]   saved_address, saved_address_next;
  logic [StatusW-1:0] first_error, first_error_next;

  logic               in_accept;
  logic               produce;
  logic               is_dot;
  logic               is_digit;
  logic [3:0]         digit_val;
  logic [AccumW-1:0]  accum_x10;
  logic [PosW-1:0]    pos_close;
  logic [AddrW-1:0]   addr_close;
  logic [AddrW-1:0]   mask_inv;
  logic               mask_bad;
  logic [AddrW-1:0]   net_w;
  logic [AddrW-1:0]   bc_w;

  // a result beat may not enter while a held result is stalled
  assign in_stall  = out_valid && out_stall && end_mark && second_text;
  assign in_accept = in_valid && !in_stall;

  // character decode
  assign is_dot    = (char_code == CharDot);
  assign is_digit  = (char_code >= CharZero) && (char_code <= CharNine);
  assign digit_val = 4'(char_code - CharZero);
  assign accum_x10 = AccumW'({octet_accum, 3'b000} + {2'b00, octet_accum, 1'b0});

  // address as it stands once the current octet closes
  assign pos_close  = (octet_position < OctetCount) ? PosW'(octet_position + 1'b1)
                                                    : octet_position;
  assign addr_close = (octet_position < OctetCount)
                      ? {assembled_addr[AddrW-9:0], octet_accum[7:0]}
                      : assembled_addr;

  // mask shape: inverted mask must be of the form 0..01..1
  assign mask_inv = ~addr_close;
  assign mask_bad = |(mask_inv & (mask_inv + 1'b1));
  assign net_w    = saved_address & addr_close;
  assign bc_w     = saved_address | mask_inv;

  // next parse state
  always_comb begin
    second_text_next    = second_text;
    octet_position_next = octet_position;
    digits_seen_next    = digits_seen;
    octet_accum_next    = octet_accum;
    assembled_addr_next = assembled_addr;
    saved_address_next  = saved_address;
    first_error_next    = first_error;
    produce             = 1'b0;
    if (in_accept) begin
      // closing an octet, on a dot or an end mark
      if (end_mark || is_dot) begin
        if (digits_seen == '0) begin
          if (first_error_next == StOk) first_error_next = StOctetCount;
        end else if (octet_accum > OctetMax) begin
          if (first_error_next == StOk) first_error_next = StOctetRange;
        end
        octet_position_next = pos_close;
        assembled_addr_next = addr_close;
        digits_seen_next    = '0;
        octet_accum_next    = '0;
      end
      if (!end_mark) begin
        if (is_dot) begin
          if (octet_position >= LastOctet) begin
            if (first_error_next == StOk) first_error_next = StOctetCount;
          end
        end else if (is_digit) begin
          if (digits_seen == MaxDigits) begin
            if (first_error_next == StOk) first_error_next = StTooManyDig;
          end else begin
            octet_accum_next = accum_x10 + AccumW'(digit_val);
            digits_seen_next = DigitW'(digits_seen + 1'b1);
          end
        end else begin
          if (first_error_next == StOk) first_error_next = StBadChar;
        end
      end else begin
        if (pos_close != OctetCount) begin
          if (first_error_next == StOk) first_error_next = StOctetCount;
        end
        octet_position_next = '0;
        assembled_addr_next = '0;
        if (!second_text) begin
          saved_address_next = addr_close;
          second_text_next   = 1'b1;
        end else begin
          if (mask_bad && first_error_next == StOk) first_error_next = StMaskShape;
          produce = 1'b1;
        end
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst || produce) begin
      second_text    <= 1'b0;
      octet_position <= '0;
      digits_seen    <= '0;
      octet_accum    <= '0;
      assembled_addr <= '0;
      saved_address  <= '0;
      first_error    <= StOk;
    end else begin
      second_text    <= second_text_next;
      octet_position <= octet_position_next;
      digits_seen    <= digits_seen_next;
      octet_accum    <= octet_accum_next;
      assembled_addr <= assembled_addr_next;
      saved_address  <= saved_address_next;
      first_error    <= first_error_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      status <= first_error_next;
      if (first_error_next == StOk) begin
        network_addr   <= net_w;
        broadcast_addr <= bc_w;
        first_host     <= net_w + 1'b1;
        last_host      <= bc_w - 1'b1;
      end else begin
        network_addr   <= '0;
        broadcast_addr <= '0;
        first_host     <= '0;
        last_host      <= '0;
      end
    end
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != StOk |->
      network_addr == '0 && broadcast_addr == '0 && first_host == '0 && last_host == '0)
    else $error("error result carries nonzero addresses");

  a_hosts: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == StOk |->
      first_host == network_addr + 1'b1 && last_host == broadcast_addr - 1'b1)
    else $error("host addresses disagree with network and broadcast");

  a_net_in_bc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (network_addr & ~broadcast_addr) == '0)
    else $error("network has bits outside broadcast");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    octet_position <= OctetCount)
    else $error("octet position beyond four");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    produce |=> !second_text && first_error == StOk && octet_position == '0 && out_valid)
    else $error("parser did not restart after a result");

endmodule
